>>> sv/rsnp_pkg.sv
// Package: shared types and character constants for the radix-suffix number parser.
`default_nettype none

package rsnp_pkg;

	// ASCII codes used by the digit decoder and the suffix decoder
	localparam logic [7:0] CH_0      = 8'h30;
	localparam logic [7:0] CH_9      = 8'h39;
	localparam logic [7:0] CH_A      = 8'h41;
	localparam logic [7:0] CH_Z      = 8'h5A;
	localparam logic [7:0] CH_LA     = 8'h61;
	localparam logic [7:0] CH_LZ     = 8'h7A;
	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_UNDER  = 8'h5F;
	localparam logic [7:0] CH_H      = 8'h48;
	localparam logic [7:0] CH_D      = 8'h44;
	localparam logic [7:0] CH_O      = 8'h4F;
	localparam logic [7:0] CH_Q      = 8'h51;
	localparam logic [7:0] CH_B      = 8'h42;

	// Digit limits per radix
	localparam logic [5:0] LIM_BIN = 6'd2;
	localparam logic [5:0] LIM_OCT = 6'd8;
	localparam logic [5:0] LIM_DEC = 6'd10;
	localparam logic [5:0] LIM_HEX = 6'd16;
	localparam logic [5:0] DIGIT_MAX = 6'd35;

	typedef enum logic [1:0] {
		RADIX_BIN = 2'd0,
		RADIX_OCT = 2'd1,
		RADIX_DEC = 2'd2,
		RADIX_HEX = 2'd3
	} radix_t;

	typedef struct packed {
		logic [7:0] char_code;
		logic       last_char;
		logic       range_check_off;
	} item_t;

	typedef struct packed {
		logic [15:0] value;
		logic [1:0]  radix_code;
		logic        bad_char;
		logic        bad_digit;
	} result_t;

	// Accumulator state: checked and unchecked values per radix
	typedef struct packed {
		logic [15:0] acc_bin;
		logic [15:0] acc_oct;
		logic [15:0] acc_dec;
		logic [15:0] acc_hex;
		logic [15:0] raw_bin;
		logic [15:0] raw_oct;
		logic [15:0] raw_dec;
		logic [15:0] raw_hex;
		logic [5:0]  max_digit_seen;
		logic        saw_bad_char;
	} fold_state_t;

endpackage

`default_nettype wire

>>> sv/rsnp_fold.sv
// Fold unit: decode one upper-cased character and step all radix accumulators.
`default_nettype none

module rsnp_fold
	import rsnp_pkg::*;
(
	input  logic [7:0]  ch,
	input  fold_state_t st,
	output fold_state_t nxt
);

	logic        is_num;
	logic        is_alpha;
	logic [7:0]  diff;
	logic [5:0]  d;
	logic [15:0] d16;
	logic [15:0] d_bin;
	logic [15:0] d_oct;
	logic [15:0] d_dec;
	logic [15:0] d_hex;

	always_comb begin
		is_num   = (ch >= CH_0) && (ch <= CH_9);
		is_alpha = (ch >= CH_A) && (ch <= CH_Z);
		if (is_num) begin
			diff = ch - CH_0;
		end else if (is_alpha) begin
			diff = ch - CH_A + 8'd10;
		end else begin
			diff = 8'd0;
		end
		d   = diff[5:0];
		d16 = {10'd0, d};

		nxt = st;
		if (!is_num && !is_alpha) begin
			nxt.saw_bad_char = 1'b1;
		end else if (d > st.max_digit_seen) begin
			nxt.max_digit_seen = d;
		end

		// out-of-range digits count as zero in the checked accumulators
		d_bin = (d < LIM_BIN) ? d16 : 16'd0;
		d_oct = (d < LIM_OCT) ? d16 : 16'd0;
		d_dec = (d < LIM_DEC) ? d16 : 16'd0;
		d_hex = (d < LIM_HEX) ? d16 : 16'd0;

		nxt.raw_bin = {st.raw_bin[14:0], 1'b0} + d16;
		nxt.raw_oct = {st.raw_oct[12:0], 3'b0} + d16;
		nxt.raw_dec = {st.raw_dec[12:0], 3'b0} + {st.raw_dec[14:0], 1'b0} + d16;
		nxt.raw_hex = {st.raw_hex[11:0], 4'b0} + d16;
		nxt.acc_bin = {st.acc_bin[14:0], 1'b0} + d_bin;
		nxt.acc_oct = {st.acc_oct[12:0], 3'b0} + d_oct;
		nxt.acc_dec = {st.acc_dec[12:0], 3'b0} + {st.acc_dec[14:0], 1'b0} + d_dec;
		nxt.acc_hex = {st.acc_hex[11:0], 4'b0} + d_hex;
	end

endmodule

`default_nettype wire

>>> sv/radix_suffix_number_parser.sv
// Top level: radix-suffix number parser, input register, fold logic and result register.
`default_nettype none

// Channel   Direction  Handshake                 Payload
// item      in         item_valid / item_stall   item_t: char_code, last_char, range_check_off
// result    out        result_valid / result_stall  result_t: value, radix_code, bad_char,
//                                                bad_digit
//
// Every character is folded while it sits in the input register; one character
// per cycle is sustained unless a final character waits on a full result register.
// A final character loads the result register as it leaves the input register.
// Reset clears the accumulators, the held-back character and both valid flags.
// A stalled result holds the input register only when it holds a final
// character; other characters keep moving under an output stall.

module radix_suffix_number_parser
	import rsnp_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    item_valid,
	output logic    item_stall,
	input  item_t   item,
	output logic    result_valid,
	input  logic    result_stall,
	output result_t result
);

	// input register
	logic        valid_s1;
	item_t       item_s1;

	// token state
	logic [7:0]  pending_q;
	logic        have_pending_q;
	fold_state_t st_q;

	// result register
	logic        result_valid_q;
	result_t     result_q;

	logic        out_free;
	logic        fire_s1;
	logic [7:0]  c;
	logic        dropped;
	logic        check;
	logic [7:0]  fin;
	logic        have_final;
	fold_state_t st_a;
	fold_state_t st1;
	fold_state_t st_b;
	result_t     res;

	// Result register frees up when empty or being taken this cycle.
	assign out_free   = !result_valid_q || !result_stall;
	// Non-final characters never need the result register.
	assign fire_s1    = valid_s1 && (!item_s1.last_char || out_free);
	assign item_stall = valid_s1 && !fire_s1;

	// Upper-case the incoming character; '$' and '_' are ignored.
	always_comb begin
		if ((item_s1.char_code >= CH_LA) && (item_s1.char_code <= CH_LZ)) begin
			c = item_s1.char_code - 8'd32;
		end else begin
			c = item_s1.char_code;
		end
		dropped = (c == CH_DOLLAR) || (c == CH_UNDER);
		check   = !item_s1.range_check_off;
	end

	// First fold: the held-back character.
	rsnp_fold u_fold_pending (
		.ch  (pending_q),
		.st  (st_q),
		.nxt (st_a)
	);

	always_comb begin
		st1        = (!dropped && have_pending_q) ? st_a : st_q;
		// A dropped final character leaves the held-back one as the final one.
		fin        = dropped ? pending_q : c;
		have_final = dropped ? have_pending_q : 1'b1;
	end

	// Second fold: a final character that is not a suffix is a decimal digit.
	rsnp_fold u_fold_final (
		.ch  (fin),
		.st  (st1),
		.nxt (st_b)
	);

	// Suffix decode and result selection.
	always_comb begin
		res            = '0;
		res.radix_code = RADIX_DEC;
		res.bad_char   = st1.saw_bad_char;
		if (have_final) begin
			case (fin) inside
				CH_H: begin
					res.radix_code = RADIX_HEX;
					res.value      = check ? st1.acc_hex : st1.raw_hex;
					res.bad_digit  = check && (st1.max_digit_seen >= LIM_HEX);
				end
				CH_D: begin
					res.radix_code = RADIX_DEC;
					res.value      = check ? st1.acc_dec : st1.raw_dec;
					res.bad_digit  = check && (st1.max_digit_seen >= LIM_DEC);
				end
				CH_O, CH_Q: begin
					res.radix_code = RADIX_OCT;
					res.value      = check ? st1.acc_oct : st1.raw_oct;
					res.bad_digit  = check && (st1.max_digit_seen >= LIM_OCT);
				end
				CH_B: begin
					res.radix_code = RADIX_BIN;
					res.value      = check ? st1.acc_bin : st1.raw_bin;
					res.bad_digit  = check && (st1.max_digit_seen >= LIM_BIN);
				end
				default: begin
					res.radix_code = RADIX_DEC;
					res.value      = check ? st_b.acc_dec : st_b.raw_dec;
					res.bad_char   = st_b.saw_bad_char;
					res.bad_digit  = check && (st_b.max_digit_seen >= LIM_DEC);
				end
			endcase
		end
	end

	// Input register: load on every transfer, advance when not stalled.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!item_stall) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			item_s1 <= item;
		end
	end

	// Token state: fold and hold back on ordinary characters, clear after the final one.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q      <= '0;
			have_pending_q <= 1'b0;
			st_q           <= '0;
		end else if (fire_s1) begin
			if (item_s1.last_char) begin
				pending_q      <= '0;
				have_pending_q <= 1'b0;
				st_q           <= '0;
			end else if (!dropped) begin
				pending_q      <= c;
				have_pending_q <= 1'b1;
				st_q           <= st1;
			end
		end
	end

	// Result register: fill on a final character, drain on transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (fire_s1 && item_s1.last_char) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1 && item_s1.last_char) begin
			result_q <= res;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	// A new result only follows a final character leaving the input register.
	a_result_from_last: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid_q) |-> $past(fire_s1 && item_s1.last_char))
		else $error("result without a final character");

	// Token state is clear after a final character.
	a_state_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		(fire_s1 && item_s1.last_char) |=> (!have_pending_q && (st_q == '0)))
		else $error("token state not cleared after final character");

	// The largest digit seen is a valid alphanumeric digit value.
	a_max_digit: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.max_digit_seen <= DIGIT_MAX)
		else $error("max digit out of range");

endmodule

`default_nettype wire
